// ----- design/dcgd_pkg.sv -----
// shared constants and types for the day count to gregorian date converter
package dcgd_pkg;

    localparam int DAY_W   = 31;
    localparam int YEAR_W  = 23;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int DOY_W   = 9;
    localparam int MONTHS  = 12;

    localparam logic [17:0] DAYS_400Y      = 18'(365 * 400 + 97);
    localparam logic [15:0] DAYS_FIRST_CENT = 16'(365 * 100 + 25);
    localparam logic [15:0] DAYS_CENT      = 16'(365 * 100 + 24);
    localparam logic [10:0] DAYS_4Y        = 11'(365 * 4 + 1);
    localparam logic [10:0] DAYS_4Y_PLAIN  = 11'(365 * 4);
    localparam logic [8:0]  DAYS_YEAR      = 9'd365;
    localparam logic [8:0]  MARCH_DOY      = 9'd59;

    localparam logic [8:0]  YEARS_400      = 9'd400;
    localparam logic [6:0]  YEARS_100      = 7'd100;

    // century boundaries inside a 400-year cycle
    localparam logic [17:0] CENT1_END = 18'(DAYS_FIRST_CENT);
    localparam logic [17:0] CENT2_END = 18'(DAYS_FIRST_CENT) + 18'(DAYS_CENT);
    localparam logic [17:0] CENT3_END = 18'(DAYS_FIRST_CENT) + 18'(2 * DAYS_CENT);

    // reciprocals for exact division by constants
    localparam int SHIFT_400Y = 49;
    localparam logic [31:0] RECIP_400Y =
        32'(((64'd1 << SHIFT_400Y) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
    localparam int SHIFT_4Y = 27;
    localparam logic [16:0] RECIP_4Y =
        17'(((64'd1 << SHIFT_4Y) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    localparam int STAGES = 7;

    typedef logic [DOY_W-1:0] doy_t;

    // first day of each month within a leap year
    localparam doy_t MONTH_START [MONTHS] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

endpackage

// ----- design/dcgd_month_lookup.sv -----
// day of leap-aligned year to month and day of month
module dcgd_month_lookup
    import dcgd_pkg::*;
(
    input  doy_t               day_of_year,
    output logic [MONTH_W-1:0] month,
    output logic [DOM_W-1:0]   day_of_month
);

    always_comb
    begin
        month = '0;
        for (int i = 1; i < MONTHS; i++)
        begin
            if (day_of_year >= MONTH_START[i])
            begin
                month = MONTH_W'(i);
            end
        end
        day_of_month = DOM_W'(day_of_year - MONTH_START[month] + 9'd1);
    end

endmodule

// ----- design/day_count_to_gregorian_date.sv -----
// top level of the day count to gregorian date converter
//
// usage
// - input channel day_valid / day_stall carries day_count, days since
//   1 january of year 0 in the proleptic gregorian calendar
// - output channel date_valid / date_stall carries year, month (0 = january)
//   and day_of_month (1 to 31), one beat per input beat, in order
// - seven register stages: 400-year divide, cycle remainder, century split,
//   four-year divide, four-year remainder, single years, month table
// - a beat accepted into stage 1 passes through every stage register in order
//   before it is presented on the output
// - throughput is one beat per cycle while the output is not stalled
// - a stall on the output holds the last stage; empty stages ahead of it
//   keep filling, and day_stall rises only when all seven stages are full
// - reset clears all stage valid bits; no state is kept between beats
module day_count_to_gregorian_date
    import dcgd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               day_valid,
    output logic               day_stall,
    input  logic [DAY_W-1:0]   day_count,
    output logic               date_valid,
    input  logic               date_stall,
    output logic [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0] month,
    output logic [DOM_W-1:0]   day_of_month
);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] rdy;

    // stage registers
    logic [DAY_W-1:0]   d1_reg;
    logic [13:0]        q1_reg;
    logic [13:0]        q2_reg;
    logic [17:0]        r2_reg;
    logic [YEAR_W-1:0]  base3_reg;
    logic [1:0]         c3_reg;
    logic [15:0]        rc3_reg;
    logic [YEAR_W-1:0]  base4_reg;
    logic [15:0]        ra4_reg;
    logic [4:0]         g4_reg;
    logic               adj4_reg;
    logic               cnz4_reg;
    logic [YEAR_W-1:0]  base5_reg;
    logic [10:0]        rg5_reg;
    logic               lp5_reg;
    logic [YEAR_W-1:0]  year6_reg;
    doy_t               doy6_reg;
    logic [YEAR_W-1:0]  year7_reg;
    logic [MONTH_W-1:0] month7_reg;
    logic [DOM_W-1:0]   dom7_reg;

    // next values
    logic [62:0]        prod1;
    logic [13:0]        q1_next;
    logic [DAY_W-1:0]   cyc_days;
    logic [17:0]        r2_next;
    logic [1:0]         c3_next;
    logic [17:0]        off3;
    logic [15:0]        rc3_next;
    logic [YEAR_W-1:0]  base3_next;
    logic               adj4_next;
    logic [15:0]        ra4_next;
    logic [32:0]        prod4;
    logic [4:0]         g4_next;
    logic [YEAR_W-1:0]  base4_next;
    logic [15:0]        grp_days;
    logic [10:0]        rg5_next;
    logic               lp5_next;
    logic [YEAR_W-1:0]  base5_next;
    logic [10:0]        len1;
    logic [1:0]         yo6;
    logic [10:0]        sub6;
    doy_t               doy_raw;
    doy_t               doy6_next;
    logic [YEAR_W-1:0]  year6_next;
    logic [MONTH_W-1:0] month7_next;
    logic [DOM_W-1:0]   dom7_next;

    // bubbles collapse: a stage loads when it is empty or the next one moves
    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || !date_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign day_stall = !rdy[0];

    // stage 1: quotient by 400-year cycle
    assign prod1   = 63'(day_count) * 63'(RECIP_400Y);
    assign q1_next = prod1[SHIFT_400Y +: 14];

    // stage 2: remainder within the cycle
    assign cyc_days = DAY_W'(q1_reg) * DAY_W'(DAYS_400Y);
    assign r2_next  = 18'(d1_reg - cyc_days);

    // stage 3: century split
    always_comb
    begin
        if (r2_reg >= CENT3_END)
        begin
            c3_next = 2'd3;
            off3    = CENT3_END;
        end
        else if (r2_reg >= CENT2_END)
        begin
            c3_next = 2'd2;
            off3    = CENT2_END;
        end
        else if (r2_reg >= CENT1_END)
        begin
            c3_next = 2'd1;
            off3    = CENT1_END;
        end
        else
        begin
            c3_next = 2'd0;
            off3    = '0;
        end
    end

    assign rc3_next   = 16'(r2_reg - off3);
    assign base3_next = YEAR_W'(q2_reg) * YEAR_W'(YEARS_400)
                      + YEAR_W'(c3_next) * YEAR_W'(YEARS_100);

    // stage 4: plain first four years of all but the first century, then four-year groups
    assign adj4_next  = (c3_reg != 2'd0) && (rc3_reg >= 16'(DAYS_4Y_PLAIN));
    assign ra4_next   = rc3_reg - (adj4_next ? 16'(DAYS_4Y_PLAIN) : 16'd0);
    assign prod4      = 33'(ra4_next) * 33'(RECIP_4Y);
    assign g4_next    = prod4[SHIFT_4Y +: 5];
    assign base4_next = base3_reg + (adj4_next ? YEAR_W'(4) : YEAR_W'(0));

    // stage 5: remainder within the four-year group
    assign grp_days   = 16'(g4_reg) * 16'(DAYS_4Y);
    assign rg5_next   = 11'(ra4_reg - grp_days);
    assign lp5_next   = !(cnz4_reg && !adj4_reg && (g4_reg == 5'd0));
    assign base5_next = base4_reg + YEAR_W'({g4_reg, 2'b00});

    // stage 6: single years and the february skip
    assign len1 = lp5_reg ? 11'(DAYS_YEAR + 9'd1) : 11'(DAYS_YEAR);

    always_comb
    begin
        if (rg5_reg >= len1 + 11'(2 * DAYS_YEAR))
        begin
            yo6  = 2'd3;
            sub6 = len1 + 11'(2 * DAYS_YEAR);
        end
        else if (rg5_reg >= len1 + 11'(DAYS_YEAR))
        begin
            yo6  = 2'd2;
            sub6 = len1 + 11'(DAYS_YEAR);
        end
        else if (rg5_reg >= len1)
        begin
            yo6  = 2'd1;
            sub6 = len1;
        end
        else
        begin
            yo6  = 2'd0;
            sub6 = '0;
        end
        doy_raw = DOY_W'(rg5_reg - sub6);
        if (!(lp5_reg && (yo6 == 2'd0)) && (doy_raw >= MARCH_DOY))
        begin
            doy6_next = doy_raw + 9'd1;
        end
        else
        begin
            doy6_next = doy_raw;
        end
    end

    assign year6_next = base5_reg + YEAR_W'(yo6);

    // stage 7: month table
    dcgd_month_lookup u_month
    (
        .day_of_year  (doy6_reg),
        .month        (month7_next),
        .day_of_month (dom7_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg[0] <= rdy[0] ? day_valid : vld_reg[0];
            for (int k = 1; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            d1_reg <= day_count;
            q1_reg <= q1_next;
        end
        if (rdy[1])
        begin
            q2_reg <= q1_reg;
            r2_reg <= r2_next;
        end
        if (rdy[2])
        begin
            base3_reg <= base3_next;
            c3_reg    <= c3_next;
            rc3_reg   <= rc3_next;
        end
        if (rdy[3])
        begin
            base4_reg <= base4_next;
            ra4_reg   <= ra4_next;
            g4_reg    <= g4_next;
            adj4_reg  <= adj4_next;
            cnz4_reg  <= (c3_reg != 2'd0);
        end
        if (rdy[4])
        begin
            base5_reg <= base5_next;
            rg5_reg   <= rg5_next;
            lp5_reg   <= lp5_next;
        end
        if (rdy[5])
        begin
            year6_reg <= year6_next;
            doy6_reg  <= doy6_next;
        end
        if (rdy[6])
        begin
            year7_reg  <= year6_reg;
            month7_reg <= month7_next;
            dom7_reg   <= dom7_next;
        end
    end

    assign date_valid   = vld_reg[STAGES-1];
    assign year         = year7_reg;
    assign month        = month7_reg;
    assign day_of_month = dom7_reg;

`ifndef SYNTH
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        day_stall |-> (&vld_reg))
        else $error("input stalled while a stage is empty");

    a_century_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (rc3_reg < DAYS_FIRST_CENT))
        else $error("century remainder out of range");

    a_group_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (rg5_reg < DAYS_4Y))
        else $error("four-year remainder out of range");

    a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> (doy6_reg < 9'd366))
        else $error("day of year out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> ((month < MONTH_W'(MONTHS)) && (day_of_month != '0)))
        else $error("month or day of month out of range");
`endif

endmodule
